/* rtl/clp_pkg.sv */
package clp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MIX_BITS  = 16;
	localparam int CW        = 32;
	// distance: exact product shifted down, three terms plus offset
	localparam int DW        = 2 * CW - FRAC_BITS + 2;
	localparam int NW        = DW + 1;
	localparam int RW        = NW + 1;
	localparam int DIFW      = CW + 1;
	localparam int PW        = DIFW + MIX_BITS + 2;
	localparam int SW        = CW + 4;
	localparam int MXW       = MIX_BITS + 1;
	localparam int CIW       = 3;

	localparam logic [CIW-1:0] CFG_NORMAL_X = 3'd0;
	localparam logic [CIW-1:0] CFG_NORMAL_Y = 3'd1;
	localparam logic [CIW-1:0] CFG_NORMAL_Z = 3'd2;
	localparam logic [CIW-1:0] CFG_OFFSET   = 3'd3;
	localparam logic [CIW-1:0] CFG_MARGIN   = 3'd4;

	localparam logic [1:0] STATUS_HIDDEN  = 2'd0;
	localparam logic [1:0] STATUS_VISIBLE = 2'd1;
	localparam logic [1:0] STATUS_CLIPPED = 2'd2;

	typedef logic [CW-1:0] word_t;
	typedef word_t [2:0][2:0] verts_t;   // [vertex][axis]
	typedef logic [DW-1:0] dist_t;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] plane_offset;
		logic [15:0]        front_margin;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] v0_x;
		logic signed [31:0] v0_y;
		logic signed [31:0] v0_z;
		logic signed [31:0] v1_x;
		logic signed [31:0] v1_y;
		logic signed [31:0] v1_z;
		logic signed [31:0] v2_x;
		logic signed [31:0] v2_y;
		logic signed [31:0] v2_z;
	} tri_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               tri_index;
		logic [1:0]         vertex_slot;
		logic               is_original;
		logic [1:0]         source_vertex;
		logic signed [31:0] cut_x;
		logic signed [31:0] cut_y;
		logic signed [31:0] cut_z;
		logic [16:0]        mix;
		logic [1:0]         edge_first;
		logic [1:0]         edge_second;
		logic               last;
	} result_t;

	typedef struct packed {
		logic       orig;
		logic [1:0] idx;
	} vref_t;

	localparam vref_t O0 = 3'b100;
	localparam vref_t O1 = 3'b101;
	localparam vref_t O2 = 3'b110;
	localparam vref_t X0 = 3'b000;
	localparam vref_t X1 = 3'b001;
	localparam vref_t X2 = 3'b010;

	// output vertex run for a front mask; item 0 in the low slot
	function automatic vref_t clip_ref(input logic [2:0] fr, input logic [2:0] i);
		vref_t [5:0] lst;
		vref_t       r;
		case (fr)
			3'b001: lst = {X0, X0, X0, X2, X0, O0};
			3'b010: lst = {X0, X0, X0, X1, O1, X0};
			3'b100: lst = {X0, X0, X0, O2, X1, X2};
			3'b011: lst = {X2, X1, O0, X1, O1, O0};
			3'b101: lst = {O2, X1, O0, X1, X0, O0};
			3'b110: lst = {X2, O2, X0, O2, O1, X0};
			default: lst = {X0, X0, X0, X0, X0, X0};
		endcase
		if (i < 3'd6) begin
			r = lst[i];
		end else begin
			r = X0;
		end
		return r;
	endfunction

endpackage

/* rtl/clp_dist.sv */
module clp_dist (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  clp_pkg::verts_t      verts,
	input  clp_pkg::cfg_t        cfg,
	output logic                 out_valid,
	output clp_pkg::verts_t      verts_out,
	output clp_pkg::dist_t [2:0] dvec
);
	import clp_pkg::*;

	logic                   valid_s1, valid_s2;
	logic signed [2*CW-1:0] prod_s1 [3][3];
	verts_t                 verts_s1, verts_s2;
	dist_t [2:0]            dist_s2;
	word_t [2:0]            nrm;
	logic signed [2*CW-1:0] dsum [3];

	assign nrm[0] = cfg.normal_x;
	assign nrm[1] = cfg.normal_y;
	assign nrm[2] = cfg.normal_z;

	// shifts of signed products round toward minus infinity
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dsum[i] = (prod_s1[i][0] >>> FRAC_BITS) + (prod_s1[i][1] >>> FRAC_BITS)
				+ (prod_s1[i][2] >>> FRAC_BITS) + (2*CW)'($signed(cfg.plane_offset));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[i][k] <= $signed(nrm[k]) * $signed(verts[i][k]);
				end
				dist_s2[i] <= dsum[i][DW-1:0];
			end
			verts_s1 <= verts;
			verts_s2 <= verts_s1;
		end
	end

	assign out_valid = valid_s2;
	assign verts_out = verts_s2;
	assign dvec      = dist_s2;

endmodule

/* rtl/clp_div.sv */
module clp_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  clp_pkg::verts_t                       verts,
	input  clp_pkg::dist_t [2:0]                  dvec,
	input  logic [15:0]                           margin,
	output logic                                  out_valid,
	output clp_pkg::verts_t                       verts_out,
	output logic [2:0]                            front,
	output logic [2:0][clp_pkg::MIX_BITS-1:0]     quo,
	output logic [2:0]                            zero,
	output logic [2:0]                            full
);
	import clp_pkg::*;

	logic                 valid_s1, valid_s2;
	verts_t               verts_s1, verts_s2;
	logic [2:0]           front_s1, front_s2;
	logic signed [NW-1:0] num_s1 [3], den_s1 [3], num_s2 [3], den_s2 [3];

	// restoring division, one quotient bit per stage; index 0 is the set-up stage
	logic                 vld_sd   [MIX_BITS+1];
	verts_t               verts_sd [MIX_BITS+1];
	logic [2:0]           front_sd [MIX_BITS+1];
	logic [2:0]           zero_sd  [MIX_BITS+1];
	logic [2:0]           full_sd  [MIX_BITS+1];
	logic [RW-1:0]        rem_sd   [MIX_BITS+1][3];
	logic [NW-1:0]        dvs_sd   [MIX_BITS+1][3];
	logic [MIX_BITS-1:0]  quo_sd   [MIX_BITS+1][3];

	logic [RW-1:0]        rem_nx   [MIX_BITS+1][3];
	logic                 bit_nx   [MIX_BITS+1][3];
	logic [RW-1:0]        shl;

	always_comb begin
		shl = '0;
		for (int k = 0; k <= MIX_BITS; k++) begin
			for (int e = 0; e < 3; e++) begin
				rem_nx[k][e] = '0;
				bit_nx[k][e] = 1'b0;
			end
		end
		for (int k = 1; k <= MIX_BITS; k++) begin
			for (int e = 0; e < 3; e++) begin
				shl = {rem_sd[k-1][e][RW-2:0], 1'b0};
				if (shl >= {1'b0, dvs_sd[k-1][e]}) begin
					rem_nx[k][e] = shl - {1'b0, dvs_sd[k-1][e]};
					bit_nx[k][e] = 1'b1;
				end else begin
					rem_nx[k][e] = shl;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int k = 0; k <= MIX_BITS; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			vld_sd[0] <= valid_s2;
			for (int k = 1; k <= MIX_BITS; k++) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int e = 0; e < 3; e++) begin
				front_s1[e] <= $signed(dvec[e]) > $signed({{(DW-16){1'b0}}, margin});
				num_s1[e]   <= NW'($signed(dvec[e]));
				den_s1[e]   <= NW'($signed(dvec[e])) - NW'($signed(dvec[(e + 1) % 3]));
				if (den_s1[e] < 0) begin
					num_s2[e] <= -num_s1[e];
					den_s2[e] <= -den_s1[e];
				end else begin
					num_s2[e] <= num_s1[e];
					den_s2[e] <= den_s1[e];
				end
				zero_sd[0][e]   <= (den_s2[e] == '0) || (num_s2[e] <= 0);
				full_sd[0][e]   <= num_s2[e] >= den_s2[e];
				rem_sd[0][e]    <= RW'(unsigned'(num_s2[e]));
				dvs_sd[0][e]    <= den_s2[e];
				quo_sd[0][e]    <= '0;
			end
			verts_s1    <= verts;
			verts_s2    <= verts_s1;
			front_s2    <= front_s1;
			verts_sd[0] <= verts_s2;
			front_sd[0] <= front_s2;
			for (int k = 1; k <= MIX_BITS; k++) begin
				verts_sd[k] <= verts_sd[k-1];
				front_sd[k] <= front_sd[k-1];
				zero_sd[k]  <= zero_sd[k-1];
				full_sd[k]  <= full_sd[k-1];
				for (int e = 0; e < 3; e++) begin
					rem_sd[k][e] <= rem_nx[k][e];
					dvs_sd[k][e] <= dvs_sd[k-1][e];
					quo_sd[k][e] <= {quo_sd[k-1][e][MIX_BITS-2:0], bit_nx[k][e]};
				end
			end
		end
	end

	assign out_valid = vld_sd[MIX_BITS];
	assign verts_out = verts_sd[MIX_BITS];
	assign front     = front_sd[MIX_BITS];
	assign zero      = zero_sd[MIX_BITS];
	assign full      = full_sd[MIX_BITS];
	always_comb begin
		for (int e = 0; e < 3; e++) begin
			quo[e] = quo_sd[MIX_BITS][e];
		end
	end

endmodule

/* rtl/clp_cut.sv */
module clp_cut (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  clp_pkg::verts_t                    verts,
	input  logic [2:0]                         front,
	input  logic [2:0][clp_pkg::MIX_BITS-1:0]  quo,
	input  logic [2:0]                         zero,
	input  logic [2:0]                         full,
	output logic                               out_valid,
	output logic [2:0]                         front_out,
	output clp_pkg::verts_t                    cut,
	output logic [2:0][clp_pkg::MXW-1:0]       mix
);
	import clp_pkg::*;

	logic                   valid_s1, valid_s2, valid_s3;
	logic [2:0]             front_s1, front_s2, front_s3;
	logic [MXW-1:0]         mix_s1 [3], mix_s2 [3], mix_s3 [3];
	logic signed [DIFW-1:0] diff_s1 [3][3];
	word_t                  pa_s1 [3][3], pa_s2 [3][3];
	logic signed [PW-1:0]   prod_s2 [3][3];
	verts_t                 cut_s3;
	logic signed [SW-1:0]   sum [3][3];
	word_t                  sat [3][3];

	always_comb begin
		for (int e = 0; e < 3; e++) begin
			for (int k = 0; k < 3; k++) begin
				sum[e][k] = SW'($signed(pa_s2[e][k])) + SW'(prod_s2[e][k] >>> MIX_BITS);
				if (sum[e][k][SW-1:CW-1] == '0 || sum[e][k][SW-1:CW-1] == '1) begin
					sat[e][k] = sum[e][k][CW-1:0];
				end else if (sum[e][k][SW-1]) begin
					sat[e][k] = {1'b1, {(CW-1){1'b0}}};
				end else begin
					sat[e][k] = {1'b0, {(CW-1){1'b1}}};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_s1 <= front;
			front_s2 <= front_s1;
			front_s3 <= front_s2;
			for (int e = 0; e < 3; e++) begin
				if (zero[e]) begin
					mix_s1[e] <= '0;
				end else if (full[e]) begin
					mix_s1[e] <= MXW'(1) << MIX_BITS;
				end else begin
					mix_s1[e] <= {1'b0, quo[e]};
				end
				mix_s2[e] <= mix_s1[e];
				mix_s3[e] <= mix_s2[e];
				for (int k = 0; k < 3; k++) begin
					diff_s1[e][k] <= DIFW'($signed(verts[(e + 1) % 3][k]))
						- DIFW'($signed(verts[e][k]));
					pa_s1[e][k]   <= verts[e][k];
					pa_s2[e][k]   <= pa_s1[e][k];
					prod_s2[e][k] <= diff_s1[e][k] * $signed({1'b0, mix_s1[e]});
					cut_s3[e][k]  <= sat[e][k];
				end
			end
		end
	end

	assign out_valid = valid_s3;
	assign front_out = front_s3;
	assign cut       = cut_s3;
	always_comb begin
		for (int e = 0; e < 3; e++) begin
			mix[e] = mix_s3[e];
		end
	end

endmodule

/* rtl/clp_emit.sv */
module clp_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [2:0]                    front,
	input  clp_pkg::verts_t               cut,
	input  logic [2:0][clp_pkg::MXW-1:0]  mix,
	output logic                          free,
	output logic                          strobe,
	output clp_pkg::result_t              result
);
	import clp_pkg::*;

	logic                  hold_q;
	logic [2:0]            cnt_q;
	logic [2:0]            front_q;
	verts_t                cut_q;
	logic [2:0][MXW-1:0]   mix_q;
	logic [1:0]            status;
	logic [2:0]            last_idx;
	logic                  is_last;
	logic                  load;
	vref_t                 ref_v;

	always_comb begin
		if (front_q == 3'b000) begin
			status   = STATUS_HIDDEN;
			last_idx = 3'd0;
		end else if (front_q == 3'b111) begin
			status   = STATUS_VISIBLE;
			last_idx = 3'd0;
		end else begin
			status   = STATUS_CLIPPED;
			last_idx = ($countones(front_q) == 1) ? 3'd2 : 3'd5;
		end
	end

	assign is_last = cnt_q == last_idx;
	assign free    = !hold_q || is_last;
	assign load    = in_valid && free;
	assign strobe  = hold_q;
	assign ref_v   = clip_ref(front_q, cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			hold_q <= 1'b1;
			cnt_q  <= '0;
		end else if (hold_q) begin
			if (is_last) begin
				hold_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			front_q <= front;
			cut_q   <= cut;
			mix_q   <= mix;
		end
	end

	always_comb begin
		result        = '0;
		result.status = status;
		result.last   = is_last;
		if (status == STATUS_CLIPPED) begin
			result.tri_index   = cnt_q >= 3'd3;
			result.vertex_slot = (cnt_q >= 3'd3) ? 2'(cnt_q - 3'd3) : cnt_q[1:0];
			if (ref_v.orig) begin
				result.is_original   = 1'b1;
				result.source_vertex = ref_v.idx;
			end else begin
				result.cut_x       = cut_q[ref_v.idx][0];
				result.cut_y       = cut_q[ref_v.idx][1];
				result.cut_z       = cut_q[ref_v.idx][2];
				result.mix         = mix_q[ref_v.idx];
				result.edge_first  = ref_v.idx;
				result.edge_second = (ref_v.idx == 2'd2) ? 2'd0 : ref_v.idx + 2'd1;
			end
		end
	end

endmodule

/* rtl/triangle_plane_clipper_unit.sv */
// channel   direction  handshake                       payload
// command   in         start && !busy                  triangle (tri_in_t)
// config    in         cfg_valid && cfg_ready          cfg_index, cfg_data
// result    out        result_valid, one cycle each    result (result_t)
//
// The first result of a triangle comes out after the distance, division, intersection and
// output registers; it gives 1, 3 or 6 results, one per cycle.
// The output sequencer sets the rate: it takes the next triangle in the cycle its last result is sent.
// busy rises when the sequencer still has results to send and a finished triangle
// waits behind it; the pipeline ahead of the sequencer then holds. The receiver cannot stall.
// Reset clears valid bits and loads the plane registers; no clearing pass.
module triangle_plane_clipper_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  clp_pkg::tri_in_t             triangle,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [clp_pkg::CIW-1:0]      cfg_index,
	input  logic [31:0]                  cfg_data,
	output logic                         result_valid,
	output clp_pkg::result_t             result
);
	import clp_pkg::*;

	cfg_t                cfg_q;
	verts_t              verts_in;
	logic                en;
	logic                dist_valid, div_valid, cut_valid, emit_free;
	verts_t              dist_verts, div_verts;
	dist_t [2:0]         dvec;
	logic [2:0]          div_front, div_zero, div_full, cut_front;
	logic [2:0][MIX_BITS-1:0] div_quo;
	verts_t              cut;
	logic [2:0][MXW-1:0] mix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x     <= '0;
			cfg_q.normal_y     <= '0;
			cfg_q.normal_z     <= 32'(1) << FRAC_BITS;
			cfg_q.plane_offset <= '0;
			cfg_q.front_margin <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NORMAL_X: cfg_q.normal_x     <= cfg_data;
				CFG_NORMAL_Y: cfg_q.normal_y     <= cfg_data;
				CFG_NORMAL_Z: cfg_q.normal_z     <= cfg_data;
				CFG_OFFSET:   cfg_q.plane_offset <= cfg_data;
				CFG_MARGIN:   cfg_q.front_margin <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign verts_in[0] = {triangle.v0_z, triangle.v0_y, triangle.v0_x};
	assign verts_in[1] = {triangle.v1_z, triangle.v1_y, triangle.v1_x};
	assign verts_in[2] = {triangle.v2_z, triangle.v2_y, triangle.v2_x};

	// hold the distance, division and intersection stages while a finished triangle waits for the sequencer
	assign en   = !(cut_valid && !emit_free);
	assign busy = !en;

	clp_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (start && en),
		.verts     (verts_in),
		.cfg       (cfg_q),
		.out_valid (dist_valid),
		.verts_out (dist_verts),
		.dvec      (dvec)
	);

	clp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dist_valid),
		.verts     (dist_verts),
		.dvec      (dvec),
		.margin    (cfg_q.front_margin),
		.out_valid (div_valid),
		.verts_out (div_verts),
		.front     (div_front),
		.quo       (div_quo),
		.zero      (div_zero),
		.full      (div_full)
	);

	clp_cut u_cut (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.verts     (div_verts),
		.front     (div_front),
		.quo       (div_quo),
		.zero      (div_zero),
		.full      (div_full),
		.out_valid (cut_valid),
		.front_out (cut_front),
		.cut       (cut),
		.mix       (mix)
	);

	clp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cut_valid),
		.front    (cut_front),
		.cut      (cut),
		.mix      (mix),
		.free     (emit_free),
		.strobe   (result_valid),
		.result   (result)
	);

`ifndef NO_ASSERTIONS
	a_busy_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> result_valid)
		else $error("busy without a result in flight");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != STATUS_CLIPPED |-> result.last)
		else $error("hidden or visible result not marked last");

	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("result run broken before last");

	a_orig_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_original |-> result.mix == '0 && result.cut_x == '0)
		else $error("original vertex carries edge data");
`endif

endmodule
